### sv/sre_pkg.sv
`timescale 1ns / 1ps

package sre_pkg;

    // operation codes
    localparam logic [1:0] K_PUSH = 2'd0;
    localparam logic [1:0] K_POP  = 2'd1;
    localparam logic [1:0] K_ROLL = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_UNDER = 2'd3;

    // modulo unit widths: magnitude of a non-negative shift and of a count
    localparam int KW = 15;
    localparam int NW = 7;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         push_value;
        logic signed [7:0]  roll_count;
        logic signed [15:0] roll_shift;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_out;
        logic [4:0] fill_out;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic          start;
        logic [KW-1:0] dividend;
        logic [NW-1:0] divisor;
    } t_mod_req;

endpackage

### sv/sre_mod.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle.
module sre_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sre_pkg::t_mod_req i_req,
    output logic              o_done,
    output logic [sre_pkg::NW-1:0] o_rem
);
    import sre_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [KW-1:0] r_dvd;
    logic [NW-1:0] r_dvs;
    logic [NW-1:0] r_rem;
    logic [NW:0]   s_trial;
    logic [NW-1:0] s_rem_nx;

    always_comb begin
        s_trial = {r_rem, r_dvd[KW-1]};
        if (s_trial >= {1'b0, r_dvs}) begin
            s_rem_nx = NW'(s_trial - {1'b0, r_dvs});
        end else begin
            s_rem_nx = s_trial[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= s_rem_nx;
                r_dvd <= {r_dvd[KW-2:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(KW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sv/stack_roll_engine_core.sv
`timescale 1ns / 1ps

// Byte stack with push, pop and roll. One item in, one result item out.
// Push and pop on a full or empty stack are flagged (overflow, underflow)
// and change nothing; a roll with a negative count or shift, or a count
// above the fill, is flagged as out of range and changes nothing; a roll of
// zero entries is a plain no-op. Items are handled one at a time; a result
// sits in an output register, so the next item is taken while it waits.
// Path from acceptance to the result being offered: a push, and a pop on an
// empty stack, go straight to the output state; other pops pass through a
// read wait; other non-roll items and rejected or zero-entry rolls read the
// top of the stack first. A roll of n entries waits for the shift remainder
// unit and is bound by the one read port and one write port of the stack and
// scratch memories: the top n entries are copied out to scratch one a cycle
// and written back rotated one a cycle. The input is taken again the cycle
// after a result is loaded into the output register.
module stack_roll_engine_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sre_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sre_pkg::t_out_item o_out
);
    import sre_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_COPY  = 4'd2;
    localparam logic [3:0] S_DRN1  = 4'd3;
    localparam logic [3:0] S_ROT   = 4'd4;
    localparam logic [3:0] S_DRN2  = 4'd5;
    localparam logic [3:0] S_RDTOP = 4'd6;
    localparam logic [3:0] S_WAIT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // memories: stack proper and scratch copy of the rolling window
    logic [7:0] r_stk_mem [STACK_DEPTH];
    logic [7:0] r_scr_mem [STACK_DEPTH];
    logic [7:0] r_stk_q;
    logic [7:0] r_scr_q;

    logic [3:0]    r_state;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_n;      // roll window size
    logic [FW-1:0] r_s;      // effective shift, below r_n
    logic [FW-1:0] r_idx;    // top position being issued
    logic [FW-1:0] r_j;      // scratch index being read in write-back
    logic          r_pv_scr; // stack read in flight, goes to scratch
    logic          r_pv_stk; // scratch read in flight, goes to stack
    logic [AW-1:0] r_pi;
    logic [AW-1:0] r_pa;
    logic [7:0]    r_res_data;
    logic [1:0]    r_res_status;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          s_acc;
    logic          s_neg;
    logic          s_push_ok;
    logic          s_pop_ok;
    logic          s_roll_go;
    logic          s_out_load;
    logic [FW-1:0] s_top;
    logic [FW-1:0] s_top_i;
    logic [FW-1:0] s_j_inc;

    logic          s_stk_we;
    logic [AW-1:0] s_stk_wa;
    logic [7:0]    s_stk_wd;
    logic          s_stk_re;
    logic [AW-1:0] s_stk_ra;

    t_mod_req      s_req;
    logic          s_mod_done;
    logic [NW-1:0] s_mod_rem;

    assign o_in_stall = (r_state != S_IDLE);
    assign s_acc      = i_in_valid && (r_state == S_IDLE);
    // result goes into the output register once it is empty or being taken
    assign s_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign s_top   = r_fill - FW'(1);
    assign s_top_i = r_fill - FW'(1) - r_idx;
    assign s_j_inc = r_j + FW'(1);

    assign s_neg     = i_in.roll_count[7] || i_in.roll_shift[15];
    assign s_push_ok = (i_in.kind == K_PUSH) && (r_fill < FW'(STACK_DEPTH));
    assign s_pop_ok  = (i_in.kind == K_POP) && (r_fill != '0);
    // roll that actually moves entries: count in 1..fill, shift non-negative
    assign s_roll_go = (i_in.kind == K_ROLL) && !s_neg
                       && (i_in.roll_count != '0)
                       && ({1'b0, i_in.roll_count[6:0]} <= 8'(r_fill));

    assign s_req.start    = s_acc && s_roll_go;
    assign s_req.dividend = i_in.roll_shift[KW-1:0];
    assign s_req.divisor  = i_in.roll_count[NW-1:0];

    sre_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_req),
        .o_done  (s_mod_done),
        .o_rem   (s_mod_rem)
    );

    // stack port: push writes in the accept cycle, rotation writes back
    // from the scratch pipeline; reads feed pop, final top and the copy pass
    assign s_stk_we = (s_acc && s_push_ok) || r_pv_stk;
    assign s_stk_wa = r_pv_stk ? r_pa : r_fill[AW-1:0];
    assign s_stk_wd = r_pv_stk ? r_scr_q : i_in.push_value;
    assign s_stk_re = (s_acc && s_pop_ok)
                      || ((r_state == S_RDTOP) && (r_fill != '0))
                      || (r_state == S_COPY);
    assign s_stk_ra = (r_state == S_COPY) ? s_top_i[AW-1:0] : s_top[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (s_stk_we) begin
            r_stk_mem[s_stk_wa] <= s_stk_wd;
        end
        if (s_stk_re) begin
            r_stk_q <= r_stk_mem[s_stk_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv_scr) begin
            r_scr_mem[r_pi] <= r_stk_q;
        end
        if (r_state == S_ROT) begin
            r_scr_q <= r_scr_mem[r_j[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pv_scr    <= 1'b0;
            r_pv_stk    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a copy or write-back read issued this cycle lands next cycle
            r_pv_scr <= (r_state == S_COPY);
            r_pv_stk <= (r_state == S_ROT);
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_in.kind)
                            K_PUSH: begin
                                if (s_push_ok) begin
                                    r_res_status <= ST_OK;
                                    r_fill       <= r_fill + FW'(1);
                                    r_res_data   <= i_in.push_value;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_res_status <= ST_OVER;
                                    r_state      <= S_RDTOP;
                                end
                            end
                            K_POP: begin
                                if (s_pop_ok) begin
                                    r_res_status <= ST_OK;
                                    r_fill       <= s_top;
                                    r_state      <= S_WAIT;
                                end else begin
                                    r_res_status <= ST_UNDER;
                                    r_res_data   <= 8'd0;
                                    r_state      <= S_OUT;
                                end
                            end
                            K_ROLL: begin
                                if (s_neg || ({1'b0, i_in.roll_count[6:0]} > 8'(r_fill))) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_RDTOP;
                                end else if (s_roll_go) begin
                                    r_res_status <= ST_OK;
                                    r_n          <= FW'(i_in.roll_count[6:0]);
                                    r_state      <= S_MOD;
                                end else begin
                                    r_res_status <= ST_OK;
                                    r_state      <= S_RDTOP;
                                end
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_RDTOP;
                            end
                        endcase
                    end
                end
                S_MOD: begin
                    if (s_mod_done) begin
                        r_s     <= FW'(s_mod_rem);
                        r_idx   <= '0;
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    // top position r_idx goes to scratch entry r_idx
                    r_pi     <= r_idx[AW-1:0];
                    r_idx    <= r_idx + FW'(1);
                    if (r_idx == r_n - FW'(1)) begin
                        r_state <= S_DRN1;
                    end
                end
                S_DRN1: begin
                    r_idx   <= '0;
                    r_j     <= r_s;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    // new top position i takes old position (i + s) mod n
                    r_pa     <= s_top_i[AW-1:0];
                    r_idx    <= r_idx + FW'(1);
                    r_j      <= (s_j_inc == r_n) ? '0 : s_j_inc;
                    if (r_idx == r_n - FW'(1)) begin
                        r_state <= S_DRN2;
                    end
                end
                S_DRN2: begin
                    r_state <= S_RDTOP;
                end
                S_RDTOP: begin
                    if (r_fill == '0) begin
                        r_res_data <= 8'd0;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_res_data <= r_stk_q;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (s_out_load) begin
                        r_out.data_out <= r_res_data;
                        r_out.fill_out <= 5'(r_fill);
                        r_out.status   <= r_res_status;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // fill never passes the stack depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(STACK_DEPTH))
        else $error("fill above stack depth");

    // rotation write-back stays inside the occupied part of the stack
    a_wb_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv_stk |-> (FW'(r_pa) < r_fill))
        else $error("roll write-back above top of stack");

    // remainder from the modulo unit is below the window size
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_mod_done && (r_state == S_MOD)) |-> (8'(s_mod_rem) < 8'(r_n)))
        else $error("roll shift remainder not below count");

    // nothing left in the memory pipeline once back in idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_pv_scr && !r_pv_stk))
        else $error("memory transfer pending in idle");

endmodule
